@@ sv/scan_code_to_ascii_fifo_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the scan code to ASCII FIFO block.
// Each macro expects clk and rst_n to be visible where it is used.
// ---------------------------------------------------------------------------
`ifndef SCAN_CODE_TO_ASCII_FIFO_MACROS_SVH
`define SCAN_CODE_TO_ASCII_FIFO_MACROS_SVH

// Same-cycle implication.
`define SCAF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCAF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/scaf_pkg.sv @@
// ---------------------------------------------------------------------------
// scaf_pkg
// Types, command codes and character ROMs for the scan code to ASCII FIFO.
// ---------------------------------------------------------------------------
`default_nettype none

package scaf_pkg;

    // Commands
    localparam logic [1:0] CMD_FEED     = 2'd0;
    localparam logic [1:0] CMD_POP_CHAR = 2'd1;
    localparam logic [1:0] CMD_POP_RAW  = 2'd2;

    // Result source
    localparam logic SRC_CHAR = 1'b0;
    localparam logic SRC_RAW  = 1'b1;

    // Scan code set 1 key codes (release bit stripped)
    localparam logic [6:0] LSHIFT_CODE = 7'h2A;
    localparam logic [6:0] RSHIFT_CODE = 7'h36;
    localparam logic [6:0] CAPS_CODE   = 7'h3A;

    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] scan_byte;
    } req_t;

    typedef struct packed {
        logic       source;
        logic [7:0] data_byte;
        logic       was_empty;
    } rsp_t;

    // Codes 58..63 are unmapped and padded with zero.
    localparam logic [7:0] ROM_PLAIN [0:63] = '{
        8'h00, 8'h1B, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'h08,
        8'h09, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'h0A,
        8'h00, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'h27, 8'h60,
        8'h00, 8'h5C, "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'h00,
        "*", 8'h00, " ",
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] ROM_SHIFTED [0:63] = '{
        8'h00, 8'h1B, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'h08,
        8'h09, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'h0A,
        8'h00, "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'h22, "~",
        8'h00, "|", "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'h00,
        "*", 8'h00, " ",
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

endpackage

`default_nettype wire

@@ sv/scan_code_to_ascii_fifo.sv @@
// ---------------------------------------------------------------------------
// scan_code_to_ascii_fifo
// Scan code set 1 decoder with a raw byte FIFO and an ASCII FIFO.
// ---------------------------------------------------------------------------
//  channel | valid     | stall     | payload        | transaction
//  --------+-----------+-----------+----------------+---------------------------
//  request | req_valid | req_stall | scaf_pkg::req_t| feed byte or pop a FIFO
//  result  | rsp_valid | rsp_stall | scaf_pkg::rsp_t| one per pop, none per feed
//
//  One request a cycle while req_stall is low. A pop result passes through the
//  registered FIFO memory read and then the result register.
//  Reset clears pointers, shift and caps flags; memory contents stay as they are.
//  Requests stall only while both the read stage and the result register hold
//  a pop result and the result side stalls.
// ---------------------------------------------------------------------------
`default_nettype none
`include "scan_code_to_ascii_fifo_macros.svh"

module scan_code_to_ascii_fifo #(
    parameter int FIFO_DEPTH = 256
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire scaf_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output scaf_pkg::rsp_t       rsp
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);

    logic [7:0] char_mem [FIFO_DEPTH];
    logic [7:0] raw_mem  [FIFO_DEPTH];

    logic [PW-1:0] char_wp_reg, char_wp_next;
    logic [PW-1:0] char_rp_reg, char_rp_next;
    logic [PW-1:0] raw_wp_reg,  raw_wp_next;
    logic [PW-1:0] raw_rp_reg,  raw_rp_next;
    logic          shift_reg,   shift_next;
    logic          caps_reg,    caps_next;

    logic          pend_valid_reg, pend_valid_next;
    logic          pend_src_reg;
    logic          pend_empty_reg;
    logic [7:0]    char_q_reg;
    logic [7:0]    raw_q_reg;

    logic          rsp_valid_reg, rsp_valid_next;
    scaf_pkg::rsp_t rsp_reg;

    logic          accept;
    logic          is_feed;
    logic          is_pop;
    logic          pend_move;
    logic          char_empty, raw_empty;
    logic          char_full,  raw_full;
    logic [PW-1:0] char_wp_inc, char_rp_inc, raw_wp_inc, raw_rp_inc;
    logic          char_push, raw_push;
    logic          char_pop,  raw_pop;
    logic [7:0]    sc;
    logic          is_shift_code;
    logic [7:0]    rom_ch;
    logic [7:0]    ch;
    logic          ch_lower, ch_upper;
    logic          lookup;

    // ---------------- handshake ----------------
    assign req_stall = pend_valid_reg && rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign is_feed   = (req.command == scaf_pkg::CMD_FEED);
    assign is_pop    = (req.command == scaf_pkg::CMD_POP_CHAR)
                    || (req.command == scaf_pkg::CMD_POP_RAW);
    assign pend_move = pend_valid_reg && (!rsp_valid_reg || !rsp_stall);

    // ---------------- pointers ----------------
    assign char_wp_inc = (char_wp_reg == PTR_LAST) ? '0 : char_wp_reg + 1'b1;
    assign char_rp_inc = (char_rp_reg == PTR_LAST) ? '0 : char_rp_reg + 1'b1;
    assign raw_wp_inc  = (raw_wp_reg  == PTR_LAST) ? '0 : raw_wp_reg  + 1'b1;
    assign raw_rp_inc  = (raw_rp_reg  == PTR_LAST) ? '0 : raw_rp_reg  + 1'b1;

    assign char_empty = (char_rp_reg == char_wp_reg);
    assign raw_empty  = (raw_rp_reg  == raw_wp_reg);
    assign char_full  = (char_wp_inc == char_rp_reg);
    assign raw_full   = (raw_wp_inc  == raw_rp_reg);

    // ---------------- decode ----------------
    assign sc            = req.scan_byte;
    assign is_shift_code = (sc[6:0] == scaf_pkg::LSHIFT_CODE)
                        || (sc[6:0] == scaf_pkg::RSHIFT_CODE);
    assign rom_ch        = shift_reg ? scaf_pkg::ROM_SHIFTED[sc[5:0]]
                                     : scaf_pkg::ROM_PLAIN[sc[5:0]];
    assign ch_lower      = (rom_ch >= "a") && (rom_ch <= "z");
    assign ch_upper      = (rom_ch >= "A") && (rom_ch <= "Z");

    always_comb
    begin
        if (caps_reg && ch_lower)
        begin
            ch = rom_ch - scaf_pkg::CASE_OFFSET;
        end
        else if (caps_reg && shift_reg && ch_upper)
        begin
            ch = rom_ch + scaf_pkg::CASE_OFFSET;
        end
        else
        begin
            ch = rom_ch;
        end
    end

    // press code that is neither shift nor caps, inside the ROM range
    assign lookup = !sc[7] && !sc[6] && !is_shift_code
                 && (sc[6:0] != scaf_pkg::CAPS_CODE);

    assign raw_push  = accept && is_feed && !raw_full;
    assign char_push = accept && is_feed && lookup && (ch != 8'h00) && !char_full;
    assign char_pop  = accept && (req.command == scaf_pkg::CMD_POP_CHAR) && !char_empty;
    assign raw_pop   = accept && (req.command == scaf_pkg::CMD_POP_RAW)  && !raw_empty;

    always_comb
    begin
        shift_next   = shift_reg;
        caps_next    = caps_reg;
        char_wp_next = char_push ? char_wp_inc : char_wp_reg;
        raw_wp_next  = raw_push  ? raw_wp_inc  : raw_wp_reg;
        char_rp_next = char_pop  ? char_rp_inc : char_rp_reg;
        raw_rp_next  = raw_pop   ? raw_rp_inc  : raw_rp_reg;
        if (accept && is_feed)
        begin
            if (is_shift_code)
            begin
                shift_next = !sc[7];
            end
            else if (!sc[7] && (sc[6:0] == scaf_pkg::CAPS_CODE))
            begin
                caps_next = !caps_reg;
            end
        end
    end

    // ---------------- result pipeline control ----------------
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (accept && is_pop)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_move)
        begin
            pend_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (pend_move)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_wp_reg    <= '0;
            char_rp_reg    <= '0;
            raw_wp_reg     <= '0;
            raw_rp_reg     <= '0;
            shift_reg      <= 1'b0;
            caps_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            char_wp_reg    <= char_wp_next;
            char_rp_reg    <= char_rp_next;
            raw_wp_reg     <= raw_wp_next;
            raw_rp_reg     <= raw_rp_next;
            shift_reg      <= shift_next;
            caps_reg       <= caps_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept && is_pop)
        begin
            pend_src_reg   <= (req.command == scaf_pkg::CMD_POP_RAW) ? scaf_pkg::SRC_RAW
                                                                      : scaf_pkg::SRC_CHAR;
            pend_empty_reg <= (req.command == scaf_pkg::CMD_POP_RAW) ? raw_empty : char_empty;
        end
        if (pend_move)
        begin
            rsp_reg.source    <= pend_src_reg;
            rsp_reg.was_empty <= pend_empty_reg;
            if (pend_empty_reg)
            begin
                rsp_reg.data_byte <= 8'h00;
            end
            else
            begin
                rsp_reg.data_byte <= (pend_src_reg == scaf_pkg::SRC_RAW) ? raw_q_reg
                                                                         : char_q_reg;
            end
        end
    end

    // ---------------- FIFO memories ----------------
    always_ff @(posedge clk)
    begin
        if (char_push)
        begin
            char_mem[char_wp_reg] <= ch;
        end
        if (char_pop)
        begin
            char_q_reg <= char_mem[char_rp_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (raw_push)
        begin
            raw_mem[raw_wp_reg] <= sc;
        end
        if (raw_pop)
        begin
            raw_q_reg <= raw_mem[raw_rp_reg];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------- assertions ----------------
    `SCAF_ASSERT_NXT(a_pop_char_empty_holds, accept && (req.command == scaf_pkg::CMD_POP_CHAR) && char_empty, $stable(char_rp_reg), "char read pointer moved on empty pop")
    `SCAF_ASSERT_NXT(a_raw_full_drops, accept && is_feed && raw_full, $stable(raw_wp_reg), "raw write pointer moved while full")
    `SCAF_ASSERT_NXT(a_pop_reaches_stage, accept && is_pop, pend_valid_reg, "accepted pop lost before read stage")
    `SCAF_ASSERT_IMP(a_feed_no_char_on_release, accept && is_feed && sc[7], !char_push, "release code pushed a character")

endmodule

`default_nettype wire
